// ===== rtl/pressure_temperature_compensation_core_defines.svh =====
// Assertion macros shared by the compensation core RTL.
// Included by the modules that check their own pipeline logic.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PTC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`define PTC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define PTC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PTC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`define PTC_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/ptc_pkg.sv =====
// Types and constants of the pressure/temperature compensation core.
// No dependencies.
package ptc_pkg;

   localparam int RAW_WIDTH          = 20;
   localparam int ADC_BITS_DEFAULT   = 20;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int CAL_COUNT          = 6;
   localparam int FIFO_DEPTH_DEFAULT = 4;
   localparam int DIV_N              = 64;
   localparam int DIV_D              = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAL_T1_T2 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAL_T3_P1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAL_P2_P3 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAL_P4_P5 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAL_P6_P7 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAL_P8_P9 = 3'd5;

   localparam logic signed [31:0] TEMP_ROUND          = 32'sd128;
   localparam logic signed [33:0] FINE_OFFSET         = 34'sd128000;
   localparam logic [63:0]        P1_BIAS             = 64'h0000_8000_0000_0000;
   localparam logic [20:0]        PRESSURE_FULL_SCALE = 21'd1048576;
   localparam logic [11:0]        PRESSURE_SCALE      = 12'd3125;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic signed [31:0]   temp;
      logic signed [31:0]   t_fine;
      logic [RAW_WIDTH-1:0] adc_p;
   } fe_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic signed [31:0] temp;
      logic               zero;
      logic               neg;
   } div_tag_type;

endpackage

// ===== rtl/ptc_fifo.sv =====
// Transaction queue between the front and back parts of the core.
// Depends on ptc_pkg.
`include "pressure_temperature_compensation_core_defines.svh"
module ptc_fifo import ptc_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  fe_item_type  push_data,
   input  logic         pop,
   output fe_item_type  pop_data,
   output q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   fe_item_type      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PTC_ASSERT_NEVER(a_no_overflow, clock, reset, push && status.full, "queue overflow")
   `PTC_ASSERT_NEVER(a_no_underflow, clock, reset, pop && status.empty, "queue underflow")
   `PTC_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count slip")

endmodule

// ===== rtl/ptc_front.sv =====
// Front part: accepts raw readings, works out fine and centi-degree temperature.
// Depends on ptc_pkg; feeds ptc_fifo.
module ptc_front import ptc_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [RAW_WIDTH-1:0] req_raw_temperature,
   input  logic [RAW_WIDTH-1:0] req_raw_pressure,
   input  cal_type              cal,
   input  q_status_type         q_status,
   output logic                 q_push,
   output fe_item_type          q_push_data
);

   localparam int FE_STAGES = 4;
   localparam logic [RAW_WIDTH-1:0] ADC_KEEP =
      RAW_WIDTH'(~((1 << (RAW_WIDTH - ADC_BITS)) - 1));

   logic [FE_STAGES-1:0] vld_ff;
   logic                 advance;
   logic [RAW_WIDTH-1:0] adc_t_ff;
   logic [RAW_WIDTH-1:0] adc_p_ff [FE_STAGES];

   logic signed [17:0] diff_a;
   logic signed [16:0] diff_b;
   logic signed [33:0] prod_a, prod_b;
   logic signed [47:0] prod_c;
   logic signed [31:0] v1_in, bb_in, v2, t_fine_in, temp_in;
   logic signed [31:0] v1_ff, bb_ff, t_fine_ff, t_fine3_ff, temp_ff;

   assign advance   = !vld_ff[FE_STAGES-1] || !q_status.full;
   assign req_stall = !advance;
   assign q_push    = vld_ff[FE_STAGES-1] && !q_status.full;
   assign q_push_data = '{temp: temp_ff, t_fine: t_fine3_ff, adc_p: adc_p_ff[FE_STAGES-1]};

   always_comb begin
      diff_a    = $signed({1'b0, adc_t_ff[RAW_WIDTH-1:3]}) - $signed({1'b0, cal.t1, 1'b0});
      diff_b    = $signed({1'b0, adc_t_ff[RAW_WIDTH-1:4]}) - $signed({1'b0, cal.t1});
      prod_a    = diff_a * $signed(cal.t2);
      prod_b    = diff_b * diff_b;
      v1_in     = $signed(prod_a[31:0]) >>> 11;
      bb_in     = $signed(prod_b[31:0]) >>> 12;
      prod_c    = bb_ff * $signed(cal.t3);
      v2        = $signed(prod_c[31:0]) >>> 14;
      t_fine_in = v1_ff + v2;
      temp_in   = ((t_fine_ff <<< 2) + t_fine_ff + TEMP_ROUND) >>> 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[FE_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         adc_t_ff    <= req_raw_temperature & ADC_KEEP;
         adc_p_ff[0] <= req_raw_pressure & ADC_KEEP;
         for (int i = 1; i < FE_STAGES; i++) begin
            adc_p_ff[i] <= adc_p_ff[i-1];
         end
         v1_ff      <= v1_in;
         bb_ff      <= bb_in;
         t_fine_ff  <= t_fine_in;
         t_fine3_ff <= t_fine_ff;
         temp_ff    <= temp_in;
      end
   end

endmodule

// ===== rtl/ptc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Depends on ptc_pkg; used by ptc_back.
module ptc_div import ptc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [DIV_N-1:0] in_dividend,
   input  logic [DIV_D-1:0] in_divisor,
   input  div_tag_type      in_tag,
   output logic             out_valid,
   output logic [DIV_N-1:0] out_quotient,
   output div_tag_type      out_tag
);

   logic             vld_ff [DIV_N];
   logic [DIV_D-1:0] rem_ff [DIV_N];
   logic [DIV_N-1:0] dq_ff  [DIV_N];
   logic [DIV_D-1:0] den_ff [DIV_N];
   div_tag_type      tag_ff [DIV_N];

   for (genvar i = 0; i < DIV_N; i++) begin : g_stage
      logic             vld_src;
      logic [DIV_D-1:0] rem_src, den_src, rem_in;
      logic [DIV_N-1:0] dq_src, dq_in;
      div_tag_type      tag_src;
      logic [DIV_D:0]   trial;
      logic             fits;

      if (i == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = '0;
         assign dq_src  = in_dividend;
         assign den_src = in_divisor;
         assign tag_src = in_tag;
      end else begin : g_next
         assign vld_src = vld_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign dq_src  = dq_ff[i-1];
         assign den_src = den_ff[i-1];
         assign tag_src = tag_ff[i-1];
      end

      always_comb begin
         trial  = {rem_src, dq_src[DIV_N-1]};
         fits   = (trial >= {1'b0, den_src});
         rem_in = fits ? DIV_D'(trial - {1'b0, den_src}) : trial[DIV_D-1:0];
         dq_in  = {dq_src[DIV_N-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (enable) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= rem_in;
            dq_ff[i]  <= dq_in;
            den_ff[i] <= den_src;
            tag_ff[i] <= tag_src;
         end
      end
   end

   assign out_valid    = vld_ff[DIV_N-1];
   assign out_quotient = dq_ff[DIV_N-1];
   assign out_tag      = tag_ff[DIV_N-1];

endmodule

// ===== rtl/ptc_back.sv =====
// Back part: 64-bit pressure compensation pipeline and result register.
// Depends on ptc_pkg and ptc_div; drains ptc_fifo.
`include "pressure_temperature_compensation_core_defines.svh"
module ptc_back import ptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cal_type      cal,
   input  q_status_type q_status,
   output logic         q_pop,
   input  fe_item_type  q_pop_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_temperature_centi,
   output logic [31:0]  rsp_pressure_q24_8,
   output logic         rsp_divide_guard
);

   localparam int PRE  = 7;
   localparam int POST = 5;

   logic            adv;
   logic [PRE-1:0]  pre_vld_ff;
   logic [POST-1:0] post_vld_ff;
   logic            rsp_valid_ff;

   logic signed [31:0]   temp_ff  [PRE-1];
   logic [RAW_WIDTH-1:0] adc_p_ff [4];
   div_tag_type          tag_ff   [POST];

   logic signed [33:0] w1_in, w1_ff;
   logic signed [67:0] sq_full;
   logic signed [49:0] m5_in, m2_in, m5_ff, m2_ff, m5b_ff, m2b_ff;
   logic [63:0]        sq_ff;
   logic signed [79:0] x6_full, x3_full;
   logic [63:0]        x6_ff, x3_ff;
   logic signed [63:0] m5_ext, m2_ext, p4_ext, x3_sh;
   logic [63:0]        w2_in, vsum_in, w2_ff, vsum_ff;
   logic [63:0]        base;
   logic [79:0]        prod1_full;
   logic [20:0]        pdiff;
   logic [63:0]        num0_in, prod1_ff, num0_ff;
   logic signed [DIV_D-1:0] den_in, den_ff;
   logic [75:0]        num_full;
   logic [63:0]        num_ff;
   logic               zero_ff;
   logic [63:0]        an_in, an_ff;
   logic [DIV_D-1:0]   ad_in, ad_ff;
   div_tag_type        tag6_ff;

   logic               div_valid;
   logic [63:0]        div_q;
   div_tag_type        div_tag;

   logic [63:0]        p_in, p_ff, p8_ff, p9_ff, p10_ff;
   logic signed [63:0] s_in;
   logic signed [79:0] t_full, x2_full;
   logic [63:0]        s_ff, t_ff, x2_in, x2_ff, x2b_ff, x2c_ff;
   logic [63:0]        pll_in, pll_ff;
   logic [31:0]        phl_in, plh_in, phl_ff, plh_ff;
   logic [63:0]        ts, x1_in, x1_ff, sum_in, sum_ff;
   logic signed [63:0] p7_ext, pr;

   logic [31:0]        temp_out_ff, pres_out_ff;
   logic               guard_out_ff;

   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_status.empty;

   always_comb begin
      w1_in   = $signed({{2{q_pop_data.t_fine[31]}}, q_pop_data.t_fine}) - FINE_OFFSET;
      sq_full = w1_ff * w1_ff;
      m5_in   = w1_ff * $signed(cal.p5);
      m2_in   = w1_ff * $signed(cal.p2);
      x6_full = $signed(sq_ff) * $signed(cal.p6);
      x3_full = $signed(sq_ff) * $signed(cal.p3);
      m5_ext  = 64'(m5b_ff);
      m2_ext  = 64'(m2b_ff);
      p4_ext  = 64'($signed(cal.p4));
      x3_sh   = $signed(x3_ff) >>> 8;
      w2_in   = x6_ff + (m5_ext << 17) + (p4_ext << 35);
      vsum_in = x3_sh + (m2_ext << 12);
      base       = P1_BIAS + vsum_ff;
      prod1_full = base * cal.p1;
      pdiff      = PRESSURE_FULL_SCALE - {1'b0, adc_p_ff[3]};
      num0_in    = (64'(pdiff) << 31) - w2_ff;
      den_in     = prod1_ff[63:33];
      num_full   = num0_ff * PRESSURE_SCALE;
      an_in = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      ad_in = den_ff[DIV_D-1] ? (DIV_D'(0) - den_ff) : den_ff;
      p_in    = div_tag.neg ? (64'd0 - div_q) : div_q;
      s_in    = $signed(p_ff) >>> 13;
      t_full  = $signed(cal.p9) * s_in;
      x2_full = $signed(cal.p8) * $signed(p_ff);
      x2_in   = $signed(x2_full[63:0]) >>> 19;
      pll_in  = t_ff[31:0] * s_ff[31:0];
      phl_in  = t_ff[63:32] * s_ff[31:0];
      plh_in  = t_ff[31:0] * s_ff[63:32];
      ts      = pll_ff + {phl_ff + plh_ff, 32'd0};
      x1_in   = $signed(ts) >>> 25;
      sum_in  = p10_ff + x1_ff + x2c_ff;
      p7_ext  = 64'($signed(cal.p7));
      pr      = ($signed(sum_ff) >>> 8) + (p7_ext << 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff   <= '0;
         post_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_vld_ff   <= {pre_vld_ff[PRE-2:0], !q_status.empty};
         post_vld_ff  <= {post_vld_ff[POST-2:0], div_valid};
         rsp_valid_ff <= post_vld_ff[POST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         temp_ff[0]  <= q_pop_data.temp;
         adc_p_ff[0] <= q_pop_data.adc_p;
         for (int i = 1; i < PRE - 1; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         for (int i = 1; i < 4; i++) begin
            adc_p_ff[i] <= adc_p_ff[i-1];
         end
         w1_ff    <= w1_in;
         sq_ff    <= sq_full[63:0];
         m5_ff    <= m5_in;
         m2_ff    <= m2_in;
         x6_ff    <= x6_full[63:0];
         x3_ff    <= x3_full[63:0];
         m5b_ff   <= m5_ff;
         m2b_ff   <= m2_ff;
         w2_ff    <= w2_in;
         vsum_ff  <= vsum_in;
         prod1_ff <= prod1_full[63:0];
         num0_ff  <= num0_in;
         den_ff   <= den_in;
         zero_ff  <= (den_in == '0);
         num_ff   <= num_full[63:0];
         an_ff    <= an_in;
         ad_ff    <= ad_in;
         tag6_ff  <= '{temp: temp_ff[PRE-2], zero: zero_ff,
                       neg: num_ff[63] ^ den_ff[DIV_D-1]};
         tag_ff[0] <= div_tag;
         for (int i = 1; i < POST; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         p_ff   <= p_in;
         s_ff   <= s_in;
         t_ff   <= t_full[63:0];
         x2_ff  <= x2_in;
         p8_ff  <= p_ff;
         pll_ff <= pll_in;
         phl_ff <= phl_in;
         plh_ff <= plh_in;
         p9_ff  <= p8_ff;
         x2b_ff <= x2_ff;
         x1_ff  <= x1_in;
         p10_ff <= p9_ff;
         x2c_ff <= x2b_ff;
         sum_ff <= sum_in;
         temp_out_ff  <= tag_ff[POST-1].temp;
         pres_out_ff  <= tag_ff[POST-1].zero ? 32'd0 : pr[31:0];
         guard_out_ff <= tag_ff[POST-1].zero;
      end
   end

   ptc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv),
      .in_valid     (pre_vld_ff[PRE-1]),
      .in_dividend  (an_ff),
      .in_divisor   (ad_ff),
      .in_tag       (tag6_ff),
      .out_valid    (div_valid),
      .out_quotient (div_q),
      .out_tag      (div_tag)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = temp_out_ff;
   assign rsp_pressure_q24_8    = pres_out_ff;
   assign rsp_divide_guard      = guard_out_ff;

   `PTC_ASSERT_IMP(a_guard_zero, clock, reset, rsp_valid && rsp_divide_guard, rsp_pressure_q24_8 == 32'd0, "guarded result carries pressure")
   `PTC_ASSERT_NXT(a_stall_freeze, clock, reset, rsp_valid && rsp_stall, pre_vld_ff == $past(pre_vld_ff), "pipeline moved under stall")

endmodule

// ===== rtl/pressure_temperature_compensation_core.sv =====
// Top level of the barometric pressure/temperature compensation core.
// Depends on ptc_pkg, ptc_front, ptc_fifo, ptc_back (and ptc_div).
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   raw_temperature, raw_pressure
//   rsp_     out        rsp_valid/rsp_stall   temperature_centi, pressure_q24_8, divide_guard
//   csr_     in         csr_write_enable      csr_index, csr_write_data
//
// One transaction per cycle while no stall holds the flow; the back pipeline includes
// the 64-stage pressure divider.
// Synchronous active-high reset clears all control state and the calibration registers.
// A result stall freezes the back pipeline; the queue then absorbs the front
// until it fills, after which req_stall rises.
module pressure_temperature_compensation_core import ptc_pkg::*; #(
   parameter int ADC_BITS   = ADC_BITS_DEFAULT,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [RAW_WIDTH-1:0]       req_raw_temperature,
   input  logic [RAW_WIDTH-1:0]       req_raw_pressure,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [31:0]         rsp_temperature_centi,
   output logic [31:0]                rsp_pressure_q24_8,
   output logic                       rsp_divide_guard,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [CSR_DATA_WIDTH-1:0] cal_ff [CAL_COUNT];
   cal_type      cal;
   q_status_type q_status;
   logic         q_push, q_pop;
   fe_item_type  q_push_data, q_pop_data;
   logic [31:0]  temp_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_COUNT; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAL_T1_T2: cal_ff[0] <= csr_write_data;
            CSR_CAL_T3_P1: cal_ff[1] <= csr_write_data;
            CSR_CAL_P2_P3: cal_ff[2] <= csr_write_data;
            CSR_CAL_P4_P5: cal_ff[3] <= csr_write_data;
            CSR_CAL_P6_P7: cal_ff[4] <= csr_write_data;
            CSR_CAL_P8_P9: cal_ff[5] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cal.t1 = cal_ff[0][15:0];
   assign cal.t2 = cal_ff[0][31:16];
   assign cal.t3 = cal_ff[1][15:0];
   assign cal.p1 = cal_ff[1][31:16];
   assign cal.p2 = cal_ff[2][15:0];
   assign cal.p3 = cal_ff[2][31:16];
   assign cal.p4 = cal_ff[3][15:0];
   assign cal.p5 = cal_ff[3][31:16];
   assign cal.p6 = cal_ff[4][15:0];
   assign cal.p7 = cal_ff[4][31:16];
   assign cal.p8 = cal_ff[5][15:0];
   assign cal.p9 = cal_ff[5][31:16];

   ptc_front #(.ADC_BITS(ADC_BITS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_temperature (req_raw_temperature),
      .req_raw_pressure    (req_raw_pressure),
      .cal                 (cal),
      .q_status            (q_status),
      .q_push              (q_push),
      .q_push_data         (q_push_data)
   );

   ptc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   ptc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cal                   (cal),
      .q_status              (q_status),
      .q_pop                 (q_pop),
      .q_pop_data            (q_pop_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (temp_bits),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_divide_guard      (rsp_divide_guard)
   );

   assign rsp_temperature_centi = $signed(temp_bits);

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of pressure_temperature_compensation_core.
// Predicts temperature, pressure and divide guard per transaction and checks results in order.
// Depends on ptc_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
   import ptc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 160;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam bit [19:0] ADC_KEEP =
      (20'hFFFFF >> (20 - ADC_BITS_DEFAULT)) << (20 - ADC_BITS_DEFAULT);

   typedef struct packed {
      bit [RAW_WIDTH-1:0] raw_temperature;
      bit [RAW_WIDTH-1:0] raw_pressure;
   } sample_type;

   typedef struct packed {
      bit [31:0] temperature_centi;
      bit [31:0] pressure_q24_8;
      bit        divide_guard;
   } reading_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [RAW_WIDTH-1:0]       req_raw_temperature;
   logic [RAW_WIDTH-1:0]       req_raw_pressure;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [31:0]         rsp_temperature_centi;
   logic [31:0]                rsp_pressure_q24_8;
   logic                       rsp_divide_guard;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   bit [31:0]   cal_words[CAL_COUNT];
   int          send_gap_pct;
   int          recv_stall_pct;
   bit          hold_arm;
   bit          hold_done;
   int          hold_left;
   int          error_count;
   int          cycle_count;

   pressure_temperature_compensation_core DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_temperature   (req_raw_temperature),
      .req_raw_pressure      (req_raw_pressure),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_divide_guard      (rsp_divide_guard),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   function automatic bit [63:0] sext16(bit [15:0] h);
      return {{48{h[15]}}, h};
   endfunction

   function automatic reading_type compensate(bit [19:0] rt, bit [19:0] rp);
      bit [31:0] adc_t, t1, t2, t3, a, v1, b, v2, t_fine, temp;
      bit [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      bit [63:0] w1, w2, s, p, num, an, ad, q, x1, x2;
      reading_type r;
      adc_t = {12'd0, rt & ADC_KEEP};
      adc_p = {44'd0, rp & ADC_KEEP};
      t1 = {16'd0, cal_words[0][15:0]};
      t2 = {{16{cal_words[0][31]}}, cal_words[0][31:16]};
      t3 = {{16{cal_words[1][15]}}, cal_words[1][15:0]};
      p1 = {48'd0, cal_words[1][31:16]};
      p2 = sext16(cal_words[2][15:0]);
      p3 = sext16(cal_words[2][31:16]);
      p4 = sext16(cal_words[3][15:0]);
      p5 = sext16(cal_words[3][31:16]);
      p6 = sext16(cal_words[4][15:0]);
      p7 = sext16(cal_words[4][31:16]);
      p8 = sext16(cal_words[5][15:0]);
      p9 = sext16(cal_words[5][31:16]);

      a = (adc_t >> 3) - (t1 << 1);
      v1 = a * t2;
      v1 = $signed(v1) >>> 11;
      b = (adc_t >> 4) - t1;
      v2 = b * b;
      v2 = $signed(v2) >>> 12;
      v2 = v2 * t3;
      v2 = $signed(v2) >>> 14;
      t_fine = v1 + v2;
      temp = t_fine * 32'd5 + 32'd128;
      temp = $signed(temp) >>> 8;

      w1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      s = w1 * w1 * p3;
      s = $signed(s) >>> 8;
      w1 = s + ((w1 * p2) << 12);
      w1 = (64'h0000_8000_0000_0000 + w1) * p1;
      w1 = $signed(w1) >>> 33;

      r.temperature_centi = temp;
      r.pressure_q24_8 = 32'd0;
      r.divide_guard = (w1 == 64'd0);
      if (!r.divide_guard) begin
         p = 64'd1048576 - adc_p;
         num = ((p << 31) - w2) * 64'd3125;
         an = num[63] ? -num : num;
         ad = w1[63] ? -w1 : w1;
         q = an / ad;
         p = (num[63] ^ w1[63]) ? -q : q;
         s = $signed(p) >>> 13;
         x1 = p9 * s * s;
         x1 = $signed(x1) >>> 25;
         x2 = p8 * p;
         x2 = $signed(x2) >>> 19;
         p = p + x1 + x2;
         p = $signed(p) >>> 8;
         p = p + (p7 << 4);
         r.pressure_q24_8 = p[31:0];
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure));
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               sample_type smp;
               smp = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_raw_temperature <= smp.raw_temperature;
               req_raw_pressure <= smp.raw_pressure;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("result transaction with no expectation waiting");
               error_count++;
            end else begin
               reading_type exp_r;
               exp_r = expected_readings.pop_front();
               if (rsp_temperature_centi !== exp_r.temperature_centi) begin
                  $error("temperature_centi: expected %0d, actual %0d",
                         $signed(exp_r.temperature_centi), rsp_temperature_centi);
                  error_count++;
               end
               if (rsp_pressure_q24_8 !== exp_r.pressure_q24_8) begin
                  $error("pressure_q24_8: expected %h, actual %h",
                         exp_r.pressure_q24_8, rsp_pressure_q24_8);
                  error_count++;
               end
               if (rsp_divide_guard !== exp_r.divide_guard) begin
                  $error("divide_guard: expected %0b, actual %0b",
                         exp_r.divide_guard, rsp_divide_guard);
                  error_count++;
               end
            end
         end
         if (hold_arm && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pressure_temperature_compensation_core regression: fail");
         $finish;
      end
   end

   task automatic write_cal(logic [CSR_INDEX_WIDTH-1:0] idx, bit [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx < CAL_COUNT)
         cal_words[idx] = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_cal(bit [31:0] c0, bit [31:0] c1, bit [31:0] c2,
                           bit [31:0] c3, bit [31:0] c4, bit [31:0] c5);
      write_cal(CSR_CAL_T1_T2, c0);
      write_cal(CSR_CAL_T3_P1, c1);
      write_cal(CSR_CAL_P2_P3, c2);
      write_cal(CSR_CAL_P4_P5, c3);
      write_cal(CSR_CAL_P6_P7, c4);
      write_cal(CSR_CAL_P8_P9, c5);
   endtask

   task automatic add_sample(bit [19:0] rt, bit [19:0] rp);
      sample_type smp;
      smp.raw_temperature = rt;
      smp.raw_pressure = rp;
      pending_samples.push_back(smp);
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++)
         add_sample(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
   endtask

   task automatic drain;
      while (pending_samples.size() > 0 || req_valid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
         2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
         default: begin send_gap_pct = 30; recv_stall_pct = 30; end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_arm = 1'b0;
      error_count = 0;
      cycle_count = 0;
      foreach (cal_words[i]) cal_words[i] = 32'd0;
      set_idling(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // calibration at reset: zero divisor
      add_sample(20'h00000, 20'h00000);
      add_sample(20'hFFFFF, 20'hFFFFF);
      add_sample(20'h7EF00, 20'h65A00);
      drain();

      // typical calibration, directed extremes
      load_cal({16'd26435, 16'd27504}, {16'd36477, -16'sd1000},
               {16'd3024, -16'sd10685}, {16'd140, 16'd2855},
               {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
      add_sample(20'h00000, 20'h00000);
      add_sample(20'hFFFFF, 20'h00000);
      add_sample(20'h00000, 20'hFFFFF);
      add_sample(20'hFFFFF, 20'hFFFFF);
      add_sample(20'h80000, 20'h7FFFF);
      add_sample(20'h7FFFF, 20'h80000);
      add_sample(20'd519888, 20'd415148);
      add_sample(20'd519888, 20'd1);
      add_sample(20'd440064, 20'd524288);
      add_sample(20'h55555, 20'hAAAAA);
      add_sample(20'hAAAAA, 20'h55555);
      add_random(PHASE_ITEMS);
      drain();

      set_idling(1);
      load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_sample(20'h00000, 20'h00000);
      add_sample(20'hFFFFF, 20'hFFFFF);
      add_random(PHASE_ITEMS);
      drain();

      set_idling(2);
      load_cal(32'h7FFF_FFFF, 32'hFFFF_7FFF, 32'h7FFF_7FFF,
               32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
      write_cal(CSR_SPARE_LOW, 32'hDEAD_BEEF);
      write_cal(CSR_SPARE_HIGH, 32'h0000_0000);
      add_sample(20'h00000, 20'hFFFFF);
      add_random(PHASE_ITEMS);
      drain();

      set_idling(3);
      load_cal(32'h8000_0000, 32'h0001_8000, 32'h8000_8000,
               32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
      add_sample(20'hFFFFF, 20'h00000);
      add_random(PHASE_ITEMS);
      drain();

      // long receiver hold-off so the core fills and stalls its input
      set_idling(0);
      load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      hold_arm = 1'b1;
      add_random(PHASE_ITEMS);
      drain();

      for (int m = 1; m < 4; m++) begin
         set_idling(m);
         load_cal({16'($urandom_range(16'hFFFF)), 16'd27504 + 16'($urandom_range(2000))},
                  {16'd36477 + 16'($urandom_range(4000)), 16'($urandom_range(16'hFFFF))},
                  $urandom, $urandom, $urandom, $urandom);
         add_random(PHASE_ITEMS / 2);
         drain();
      end

      if (error_count == 0)
         $display("pressure_temperature_compensation_core regression: pass");
      else
         $display("pressure_temperature_compensation_core regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_fifo.sv
rtl/ptc_front.sv
rtl/ptc_div.sv
rtl/ptc_back.sv
rtl/pressure_temperature_compensation_core.sv
test/testbench.sv
